### rtl/olfo_pkg.sv
// Package for the ordered list front-operations block.
// Holds the item structs, command and status codes and sizing constants.
// No dependencies.
package olfo_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int LEN_W    = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic signed [DATA_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  removed_value;
    logic [LEN_W-1:0]          length;
    logic                      is_empty;
  } out_item_t;

  // Shift controls broadcast to every cell in the row.
  typedef struct packed {
    logic push;
    logic pop;
    logic del;
  } cell_ctrl_t;

endpackage

### rtl/olfo_cell.sv
// One storage cell of the ordered list row.
// Compares its entry against the command value and shifts toward either neighbor.
// Depends on olfo_pkg.
module olfo_cell (
  input  logic                                    clk,
  input  olfo_pkg::cell_ctrl_t                    ctrl,
  input  logic                                    occ,
  input  logic signed [olfo_pkg::DATA_W-1:0]      value,
  input  logic signed [olfo_pkg::DATA_W-1:0]      from_head,
  input  logic signed [olfo_pkg::DATA_W-1:0]      from_tail,
  input  logic                                    hit_in,
  input  logic [olfo_pkg::DATA_W-1:0]             acc_in,
  output logic signed [olfo_pkg::DATA_W-1:0]      data,
  output logic                                    hit_out,
  output logic [olfo_pkg::DATA_W-1:0]             acc_out
);
  import olfo_pkg::*;

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;
  logic                     match;
  logic                     first;

  assign match   = occ && (data_r == value);
  assign first   = match && !hit_in;
  assign hit_out = hit_in || match;
  // Only the match nearest the head contributes its entry to the removed value.
  assign acc_out = acc_in | (first ? data_r : '0);
  assign data    = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.push) begin
      data_nxt = from_head;
    end else if (ctrl.pop || (ctrl.del && hit_out)) begin
      data_nxt = from_tail;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

### rtl/ordered_list_front_ops.sv
// Bounded ordered list of signed 32-bit values, up to CAPACITY entries, with
// push-front, pop-front, delete-first-match and clear. The block returns
// exactly one result item for each command item, held in an output register
// that is loaded on acceptance. A new command is taken only while that register
// is empty or while its result leaves in the same cycle, so with out_ready held
// high one command item is accepted every cycle. All cells compare and shift in
// parallel; the first-match priority ripples through the row of cells within
// that cycle. No clearing pass is needed after reset.
module ordered_list_front_ops (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  olfo_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output olfo_pkg::out_item_t  out_item
);
  import olfo_pkg::*;

  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  out_item_t           out_r;
  out_item_t           out_nxt;

  logic                in_fire;
  logic                full;
  logic                empty;
  cell_ctrl_t          ctrl;

  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic                     hit_chain [CAPACITY+1];
  logic [DATA_W-1:0]        acc_chain [CAPACITY+1];

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign ctrl.push = in_fire && (in_item.cmd == CMD_PUSH) && !full;
  assign ctrl.pop  = in_fire && (in_item.cmd == CMD_POP) && !empty;
  assign ctrl.del  = in_fire && (in_item.cmd == CMD_DELETE);

  assign hit_chain[0] = 1'b0;
  assign acc_chain[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] head_side;
    logic signed [DATA_W-1:0] tail_side;

    if (i == 0) begin : g_head
      assign head_side = in_item.value;
    end else begin : g_mid
      assign head_side = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign tail_side = '0;
    end else begin : g_body
      assign tail_side = cell_data[i+1];
    end

    olfo_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (count_r > CNT_W'(i)),
      .value     (in_item.value),
      .from_head (head_side),
      .from_tail (tail_side),
      .hit_in    (hit_chain[i]),
      .acc_in    (acc_chain[i]),
      .data      (cell_data[i]),
      .hit_out   (hit_chain[i+1]),
      .acc_out   (acc_chain[i+1])
    );
  end

  always_comb begin
    count_nxt             = count_r;
    out_nxt               = out_r;
    out_valid_nxt         = out_valid_r && !out_ready;
    out_nxt.removed_value = '0;
    out_nxt.status        = ST_OK;
    case (in_item.cmd)
      CMD_PUSH: begin
        if (full) begin
          out_nxt.status = ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_POP: begin
        if (empty) begin
          out_nxt.status = ST_EMPTY;
        end else begin
          out_nxt.removed_value = cell_data[0];
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_DELETE: begin
        if (empty) begin
          out_nxt.status = ST_EMPTY;
        end else if (hit_chain[CAPACITY]) begin
          out_nxt.removed_value = acc_chain[CAPACITY];
          count_nxt = count_r - 1'b1;
        end else begin
          out_nxt.status = ST_NOTFOUND;
        end
      end
      CMD_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    out_nxt.length   = LEN_W'(count_nxt);
    out_nxt.is_empty = (count_nxt == '0);
    if (!in_fire) begin
      count_nxt = count_r;
      out_nxt   = out_r;
    end else begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.push |=> count_r == $past(count_r) + 1'b1)
    else $error("accepted push did not grow the list");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted item produced no result");

  a_fail_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status != ST_OK) |-> out_r.removed_value == '0)
    else $error("failed command reports a removed value");

  a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_item.cmd == CMD_DELETE) && !hit_chain[CAPACITY]
      |=> count_r == $past(count_r))
    else $error("unmatched delete changed the list");
`endif

endmodule
